/* rtl/core/kbs_pkg.sv */
// Shared types and constants for the key bubble sorter.
// No dependencies; every other file of the block refers to it by scoped names.
package kbs_pkg;

  // Width of the arrival position tag.
  localparam int POS_W = 6;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } back_state_e;

  // Classification of one accepted item, made by the front.
  typedef struct packed {
    logic             store;  // key fits in the store
    logic             last;   // closes the set
    logic             ovf;    // a key of this set was dropped so far
    logic [POS_W-1:0] pos;    // arrival position
  } item_ctl_t;

  localparam int CTL_W = $bits(item_ctl_t);

endpackage

/* rtl/core/kbs_if.sv */
// Handshake channels of the key bubble sorter: input keys and sorted results.
// Depends on kbs_pkg.
interface kbs_in_if #(
  parameter int KEY_BITS = 32
);
  logic                       valid;
  logic                       ready;
  logic signed [KEY_BITS-1:0] key;
  logic                       set_end;

  modport source (output valid, key, set_end, input ready);
  modport sink   (input valid, key, set_end, output ready);
endinterface

interface kbs_out_if #(
  parameter int KEY_BITS = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [KEY_BITS-1:0]     sorted_key;
  logic [kbs_pkg::POS_W-1:0]      origin_pos;
  logic                           run_end;
  logic                           overflowed;

  modport source (output valid, sorted_key, origin_pos, run_end, overflowed, input ready);
  modport sink   (input valid, sorted_key, origin_pos, run_end, overflowed, output ready);
endinterface

/* rtl/core/key_bubble_sorter.sv */
// Key bubble sorter, top level. Collects a set of signed keys, sorts them
// ascending (stable) and returns each key with its arrival position.
// Channels: in_i (key, set_end) and out_o (sorted_key, origin_pos, run_end,
// overflowed), valid/ready; an item moves when both are high at a clock edge.
// Keys are accepted one per cycle while the four-entry queue is not full; the
// back loads them into a row of DEPTH cells at one per cycle while it loads a
// set. The item with set_end closes the set: the row then runs n odd-even
// exchange phases (n = keys stored, one phase per cycle) and shifts out one
// result per cycle through an output register while the receiver is ready.
// The row is the limiting unit: load, sort and emit of a set occupy it alone.
// Keys past DEPTH are dropped and flag every result of that set as overflowed.
// While a set sorts or drains, the front still takes up to four new keys.
// A stalled receiver holds the output register and freezes the shift-out.
// Reset empties the queue, the cells and the output register; no result is
// pending afterwards and the next key starts a new set at position 0.
module key_bubble_sorter #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kbs_in_if.sink    in_i,
  kbs_out_if.source out_o
);

  localparam int Q_W = KEY_BITS + kbs_pkg::CTL_W;

  logic                 f_push;
  logic [KEY_BITS-1:0]  f_key;
  kbs_pkg::item_ctl_t   f_ctl;
  logic                 q_full;
  logic                 q_valid;
  logic                 q_pop;
  logic [Q_W-1:0]       q_data;
  logic [KEY_BITS-1:0]  b_key;
  kbs_pkg::item_ctl_t   b_ctl;

  kbs_front #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (f_push),
    .q_key_o  (f_key),
    .q_ctl_o  (f_ctl)
  );

  kbs_fifo #(
    .WIDTH (Q_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  ({f_key, f_ctl}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .valid_o (q_valid)
  );

  assign b_key = q_data[Q_W-1:kbs_pkg::CTL_W];
  assign b_ctl = kbs_pkg::item_ctl_t'(q_data[kbs_pkg::CTL_W-1:0]);

  kbs_back #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_key_i   (b_key),
    .q_ctl_i   (b_ctl),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

/* rtl/core/kbs_front.sv */
// Front of the key bubble sorter: accepts keys, tags the arrival position,
// detects store overflow and pushes classified items. Depends on kbs_pkg, kbs_if.
module kbs_front #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kbs_in_if.sink                in_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output logic [KEY_BITS-1:0]   q_key_o,
  output kbs_pkg::item_ctl_t    q_ctl_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic             store;

  assign in_i.ready = !q_full_i;
  assign q_push_o   = in_i.valid && !q_full_i;
  assign store      = (cnt_q != CNT_W'(DEPTH));

  assign q_key_o       = in_i.key;
  assign q_ctl_o.store = store;
  assign q_ctl_o.last  = in_i.set_end;
  assign q_ctl_o.ovf   = ovf_q || !store;
  assign q_ctl_o.pos   = kbs_pkg::POS_W'(cnt_q);

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (q_push_o) begin
      if (in_i.set_end) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (store) begin
        cnt_d = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

/* rtl/core/kbs_fifo.sv */
// Short queue between the front and the back of the key bubble sorter.
// Depends on kbs_pkg for its depth.
module kbs_fifo #(
  parameter int WIDTH = 42
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             valid_o
);

  logic [WIDTH-1:0]         mem_q [kbs_pkg::Q_DEPTH];
  logic [kbs_pkg::Q_AW-1:0] wr_q, rd_q;
  logic [kbs_pkg::Q_AW:0]   cnt_q;
  logic                     do_push, do_pop;

  assign full_o  = (cnt_q == (kbs_pkg::Q_AW + 1)'(kbs_pkg::Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

endmodule

/* rtl/core/kbs_back.sv */
// Back of the key bubble sorter: a row of key cells that loads a set, sorts it
// by odd-even adjacent exchange and shifts it out through an output register.
// Depends on kbs_pkg, kbs_if.
module kbs_back #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  logic [KEY_BITS-1:0]   q_key_i,
  input  kbs_pkg::item_ctl_t    q_ctl_i,
  output logic                  q_pop_o,
  kbs_out_if.source             out_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  kbs_pkg::back_state_e state_q, state_d;

  logic [KEY_BITS-1:0]       key_q [DEPTH];
  logic [KEY_BITS-1:0]       key_d [DEPTH];
  logic [kbs_pkg::POS_W-1:0] pos_q [DEPTH];
  logic [kbs_pkg::POS_W-1:0] pos_d [DEPTH];
  logic [DEPTH-1:0]          vld_q, vld_d;

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] phase_q, phase_d;
  logic             ovf_q, ovf_d;

  logic                      out_vld_q, out_vld_d;
  logic [KEY_BITS-1:0]       out_key_q, out_key_d;
  logic [kbs_pkg::POS_W-1:0] out_pos_q, out_pos_d;
  logic                      out_end_q, out_end_d;
  logic                      out_ovf_q, out_ovf_d;

  logic             pop;
  logic             take;
  logic [IDX_W-1:0] widx;

  assign q_pop_o = pop;
  assign pop     = (state_q == kbs_pkg::ST_LOAD) && q_valid_i;
  assign take    = (state_q == kbs_pkg::ST_EMIT) && (!out_vld_q || out_o.ready);
  assign widx    = q_ctl_i.pos[IDX_W-1:0];

  assign out_o.valid      = out_vld_q;
  assign out_o.sorted_key = out_key_q;
  assign out_o.origin_pos = out_pos_q;
  assign out_o.run_end    = out_end_q;
  assign out_o.overflowed = out_ovf_q;

  // Cell row: load, exchange, shift
  always_comb begin
    key_d = key_q;
    pos_d = pos_q;
    vld_d = vld_q;
    case (state_q)
      kbs_pkg::ST_LOAD: begin
        if (pop && q_ctl_i.store) begin
          key_d[widx] = q_key_i;
          pos_d[widx] = q_ctl_i.pos;
          vld_d[widx] = 1'b1;
        end
      end
      kbs_pkg::ST_SORT: begin
        // exchange only on strictly greater so equal keys keep arrival order
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (((i % 2) == int'(phase_q[0])) && vld_q[i] && vld_q[i+1] &&
              ($signed(key_q[i]) > $signed(key_q[i+1]))) begin
            key_d[i]   = key_q[i+1];
            key_d[i+1] = key_q[i];
            pos_d[i]   = pos_q[i+1];
            pos_d[i+1] = pos_q[i];
          end
        end
      end
      kbs_pkg::ST_EMIT: begin
        if (take) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            key_d[i] = key_q[i+1];
            pos_d[i] = pos_q[i+1];
            vld_d[i] = vld_q[i+1];
          end
          vld_d[DEPTH-1] = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer and output register
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    ovf_d     = ovf_q;
    out_vld_d = out_vld_q;
    out_key_d = out_key_q;
    out_pos_d = out_pos_q;
    out_end_d = out_end_q;
    out_ovf_d = out_ovf_q;
    if (out_o.ready) out_vld_d = 1'b0;
    case (state_q)
      kbs_pkg::ST_LOAD: begin
        if (pop) begin
          ovf_d = q_ctl_i.ovf;
          if (q_ctl_i.store) cnt_d = cnt_q + 1'b1;
          if (q_ctl_i.last) begin
            phase_d = '0;
            state_d = kbs_pkg::ST_SORT;
          end
        end
      end
      kbs_pkg::ST_SORT: begin
        // one phase per stored key is enough for odd-even exchange
        phase_d = phase_q + 1'b1;
        if (CNT_W'(phase_q + 1'b1) >= cnt_q) state_d = kbs_pkg::ST_EMIT;
      end
      kbs_pkg::ST_EMIT: begin
        if (take) begin
          out_vld_d = 1'b1;
          out_key_d = key_q[0];
          out_pos_d = pos_q[0];
          out_end_d = (cnt_q == CNT_W'(1));
          out_ovf_d = ovf_q;
          cnt_d     = cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            ovf_d   = 1'b0;
            state_d = kbs_pkg::ST_LOAD;
          end
        end
      end
      default: state_d = kbs_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= kbs_pkg::ST_LOAD;
      vld_q     <= '0;
      cnt_q     <= '0;
      phase_q   <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      cnt_q     <= cnt_d;
      phase_q   <= phase_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    pos_q     <= pos_d;
    out_key_q <= out_key_d;
    out_pos_q <= out_pos_d;
    out_end_q <= out_end_d;
    out_ovf_q <= out_ovf_d;
  end

endmodule
